// ===== rtl/core/pip_pkg.sv =====
package pip_pkg;

  // Command codes of the input word.
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_TEST   = 2'd2;

  localparam int unsigned RES_COUNT_BITS = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL1,
    ST_TAIL0,
    ST_WAIT
  } pip_state_t;

  // Control from the sequencer to the edge evaluator.
  typedef struct packed {
    logic clr;    // new test: latch the point, restart the count
    logic vtx;    // a stored vertex arrives from the chain
    logic tail1;  // closing edge from the last vertex to the first
    logic tail0;  // edge from the first vertex to the second
    logic fin;    // marks the end of the test in the pipeline
  } pip_ctl_t;

endpackage

// ===== rtl/core/pip_vertex_cell.sv =====
module pip_vertex_cell
  import pip_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         shift_en,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y
);

  logic signed [COORD_BITS-1:0] x_r;
  logic signed [COORD_BITS-1:0] y_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      x_r <= in_x;
      y_r <= in_y;
    end
  end

  assign out_x = x_r;
  assign out_y = y_r;

endmodule

// ===== rtl/core/pip_edge_eval.sv =====
module pip_edge_eval
  import pip_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int CNT_W      = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pip_ctl_t                     ctl,
  input  logic signed [COORD_BITS-1:0] pt_x,
  input  logic signed [COORD_BITS-1:0] pt_y,
  input  logic signed [COORD_BITS-1:0] vin_x,
  input  logic signed [COORD_BITS-1:0] vin_y,
  output logic                         done,
  output logic                         inside_res,
  output logic [RES_COUNT_BITS-1:0]    crossing_count
);

  localparam int C = COORD_BITS;
  localparam int D = COORD_BITS + 1;
  localparam int P = 2 * D;

  // Test point.
  logic signed [C-1:0] tx_r, ty_r;

  // Vertex window: first two vertices, the current and the previous one.
  logic [1:0]          seen_r;
  logic signed [C-1:0] v0x_r, v0y_r, v1x_r, v1y_r;
  logic signed [C-1:0] curx_r, cury_r, prevy_r;

  // Stage A: the selected edge and the y of the vertex before it.
  logic                ea_vld_r, ea_fin_r;
  logic                ea_vld_nxt;
  logic signed [C-1:0] ea_yp_r, ea_x0_r, ea_y0_r, ea_x1_r, ea_y1_r;
  logic signed [C-1:0] ea_yp_nxt, ea_x0_nxt, ea_y0_nxt, ea_x1_nxt, ea_y1_nxt;

  // Stage B: differences after the sign of the y span has been normalised.
  logic                eb_vld_r, eb_fin_r, eb_corr_r;
  logic signed [D-1:0] eb_p_r, eb_q_r, eb_r_r, eb_s_r;
  logic                eb_vld_nxt, eb_corr_nxt;
  logic signed [D-1:0] eb_p_nxt, eb_q_nxt, eb_r_nxt, eb_s_nxt;
  logic signed [D-1:0] dy, ay;
  logic                skip;

  // Stage C: the two cross products.
  logic                ec_vld_r, ec_fin_r, ec_corr_r;
  logic signed [P-1:0] ec_p1_r, ec_p2_r;
  logic signed [P-1:0] ec_p1_nxt, ec_p2_nxt;

  // Stage D: count and result.
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [CNT_W+RES_COUNT_BITS-1:0] cnt_ext;
  logic                      done_r;
  logic                      inside_r;
  logic [RES_COUNT_BITS-1:0] count_r;

  // Window and test point.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 2'd0;
    end else if (ctl.clr) begin
      seen_r <= 2'd0;
    end else if (ctl.vtx && !seen_r[1]) begin
      seen_r <= seen_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      tx_r <= pt_x;
      ty_r <= pt_y;
    end
    if (ctl.vtx) begin
      if (seen_r == 2'd0) begin
        v0x_r <= vin_x;
        v0y_r <= vin_y;
      end
      if (seen_r == 2'd1) begin
        v1x_r <= vin_x;
        v1y_r <= vin_y;
      end
      prevy_r <= cury_r;
      curx_r  <= vin_x;
      cury_r  <= vin_y;
    end
  end

  // Edge selection. Edges need at least two vertices.
  always_comb begin
    ea_vld_nxt = 1'b0;
    ea_yp_nxt  = prevy_r;
    ea_x0_nxt  = curx_r;
    ea_y0_nxt  = cury_r;
    ea_x1_nxt  = vin_x;
    ea_y1_nxt  = vin_y;
    if (ctl.vtx && seen_r[1]) begin
      ea_vld_nxt = 1'b1;
    end else if (ctl.tail1 && seen_r[1]) begin
      ea_vld_nxt = 1'b1;
      ea_x1_nxt  = v0x_r;
      ea_y1_nxt  = v0y_r;
    end else if (ctl.tail0 && seen_r[1]) begin
      ea_vld_nxt = 1'b1;
      ea_yp_nxt  = cury_r;
      ea_x0_nxt  = v0x_r;
      ea_y0_nxt  = v0y_r;
      ea_x1_nxt  = v1x_r;
      ea_y1_nxt  = v1y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ea_vld_r <= 1'b0;
      ea_fin_r <= 1'b0;
    end else begin
      ea_vld_r <= ea_vld_nxt;
      ea_fin_r <= ctl.fin;
    end
  end

  always_ff @(posedge clk) begin
    ea_yp_r <= ea_yp_nxt;
    ea_x0_r <= ea_x0_nxt;
    ea_y0_r <= ea_y0_nxt;
    ea_x1_r <= ea_x1_nxt;
    ea_y1_r <= ea_y1_nxt;
  end

  // Rejection tests, differences, and the correction for a start vertex on the ray
  // whose neighbours lie strictly on opposite sides.
  always_comb begin
    dy   = D'(ea_y1_r) - D'(ea_y0_r);
    ay   = D'(ty_r) - D'(ea_y0_r);
    skip = (ea_y0_r == ea_y1_r) ||
           (ea_x0_r < tx_r && ea_x1_r < tx_r) ||
           (ea_y0_r > ty_r && ea_y1_r > ty_r) ||
           (ea_y0_r < ty_r && ea_y1_r < ty_r);
    eb_vld_nxt  = ea_vld_r && !skip;
    eb_corr_nxt = (ea_y0_r == ty_r) &&
                  ((ea_y1_r > ea_y0_r && ea_yp_r < ea_y0_r) ||
                   (ea_y1_r < ea_y0_r && ea_yp_r > ea_y0_r));
    eb_p_nxt = D'(ea_x1_r) - D'(ea_x0_r);
    eb_r_nxt = D'(tx_r) - D'(ea_x0_r);
    if (dy < 0) begin
      eb_q_nxt = -ay;
      eb_s_nxt = -dy;
    end else begin
      eb_q_nxt = ay;
      eb_s_nxt = dy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eb_vld_r <= 1'b0;
      eb_fin_r <= 1'b0;
    end else begin
      eb_vld_r <= eb_vld_nxt;
      eb_fin_r <= ea_fin_r;
    end
  end

  always_ff @(posedge clk) begin
    eb_corr_r <= eb_corr_nxt;
    eb_p_r    <= eb_p_nxt;
    eb_q_r    <= eb_q_nxt;
    eb_r_r    <= eb_r_nxt;
    eb_s_r    <= eb_s_nxt;
  end

  assign ec_p1_nxt = eb_p_r * eb_q_r;
  assign ec_p2_nxt = eb_r_r * eb_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ec_vld_r <= 1'b0;
      ec_fin_r <= 1'b0;
    end else begin
      ec_vld_r <= eb_vld_r;
      ec_fin_r <= eb_fin_r;
    end
  end

  always_ff @(posedge clk) begin
    ec_corr_r <= eb_corr_r;
    ec_p1_r   <= ec_p1_nxt;
    ec_p2_r   <= ec_p2_nxt;
  end

  // The crossing lies at or right of the point unless p*q < r*s.
  always_comb begin
    cnt_nxt = cnt_r;
    if (ec_vld_r && !(ec_p1_r < ec_p2_r) && !ec_corr_r) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    cnt_ext = {{RES_COUNT_BITS{1'b0}}, cnt_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= ec_fin_r;
      if (ctl.clr) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ec_fin_r) begin
      inside_r <= cnt_nxt[0];
      count_r  <= cnt_ext[RES_COUNT_BITS-1:0];
    end
  end

  assign done           = done_r;
  assign inside_res     = inside_r;
  assign crossing_count = count_r;

endmodule

// ===== rtl/core/point_in_polygon_test_unit.sv =====
// Clear and append words give no result.
// A test word walks the vertex chain once, one vertex a cycle, then runs the
// two closing edges through a four-stage evaluator; busy drops in the cycle
// after the result strobe.
// The result is shown for one cycle only; the receiver cannot stall it.
// Reset empties the polygon and returns to idle; stored vertices are not cleared.
module point_in_polygon_test_unit
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_command,
  input  logic signed [COORD_BITS-1:0] in_coord_x,
  input  logic signed [COORD_BITS-1:0] in_coord_y,
  output logic                         out_valid,
  output logic                         out_inside_res,
  output logic [RES_COUNT_BITS-1:0]    out_crossing_count
);

  localparam int TW = $clog2(MAX_VERTICES + 1);
  localparam int SW = $clog2(MAX_VERTICES);

  pip_state_t state_r, state_nxt;
  logic [TW-1:0] vtx_total_r;
  logic [SW-1:0] step_r;
  logic          accept, is_clear, is_append, is_test, full, stream_on, shift_en;
  logic [TW:0]   step_sum;
  pip_ctl_t      ctl;

  logic signed [COORD_BITS-1:0] chain_in_x, chain_in_y;
  logic signed [COORD_BITS-1:0] chain_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] chain_y [MAX_VERTICES];

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign full   = (vtx_total_r == TW'(MAX_VERTICES));

  always_comb begin
    is_clear  = 1'b0;
    is_append = 1'b0;
    is_test   = 1'b0;
    unique case (in_command)
      CMD_CLEAR:  is_clear  = 1'b1;
      CMD_APPEND: is_append = 1'b1;
      CMD_TEST:   is_test   = 1'b1;
      default:    ;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept && is_test) state_nxt = ST_SCAN;
      ST_SCAN:  if (step_r == SW'(MAX_VERTICES - 1)) state_nxt = ST_TAIL1;
      ST_TAIL1: state_nxt = ST_TAIL0;
      ST_TAIL0: state_nxt = ST_WAIT;
      ST_WAIT:  if (out_valid) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // The stored vertices leave the far end of the chain oldest first, in the
  // last vertex_total steps of a full rotation.
  assign step_sum  = (TW + 1)'(step_r) + (TW + 1)'(vtx_total_r);
  assign stream_on = (step_sum >= (TW + 1)'(MAX_VERTICES));

  // Outputs of the sequencer.
  always_comb begin
    ctl        = '0;
    shift_en   = 1'b0;
    chain_in_x = in_coord_x;
    chain_in_y = in_coord_y;
    unique case (state_r)
      ST_IDLE: begin
        ctl.clr  = accept && is_test;
        shift_en = accept && is_append && !full;
      end
      ST_SCAN: begin
        shift_en   = 1'b1;
        chain_in_x = chain_x[MAX_VERTICES-1];
        chain_in_y = chain_y[MAX_VERTICES-1];
        ctl.vtx    = stream_on;
      end
      ST_TAIL1: ctl.tail1 = 1'b1;
      ST_TAIL0: begin
        ctl.tail0 = 1'b1;
        ctl.fin   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vtx_total_r <= '0;
      step_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept && is_clear) begin
        vtx_total_r <= '0;
      end else if (accept && is_append && !full) begin
        vtx_total_r <= vtx_total_r + TW'(1);
      end
      if (accept) begin
        step_r <= '0;
      end else if (state_r == ST_SCAN) begin
        step_r <= step_r + SW'(1);
      end
    end
  end

  // Vertex chain: appends shift in at the near end; a test rotates it once.
  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    if (k == 0) begin : g_head
      pip_vertex_cell #(.COORD_BITS(COORD_BITS)) u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .in_x     (chain_in_x),
        .in_y     (chain_in_y),
        .out_x    (chain_x[k]),
        .out_y    (chain_y[k])
      );
    end else begin : g_body
      pip_vertex_cell #(.COORD_BITS(COORD_BITS)) u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .in_x     (chain_x[k-1]),
        .in_y     (chain_y[k-1]),
        .out_x    (chain_x[k]),
        .out_y    (chain_y[k])
      );
    end
  end

  pip_edge_eval #(
    .COORD_BITS (COORD_BITS),
    .CNT_W      (TW)
  ) u_eval (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .pt_x           (in_coord_x),
    .pt_y           (in_coord_y),
    .vin_x          (chain_x[MAX_VERTICES-1]),
    .vin_y          (chain_y[MAX_VERTICES-1]),
    .done           (out_valid),
    .inside_res     (out_inside_res),
    .crossing_count (out_crossing_count)
  );

  a_result_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == ST_WAIT))
    else $error("result word outside the wait state");

  a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    vtx_total_r <= TW'(MAX_VERTICES))
    else $error("vertex total beyond capacity");

  a_test_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_test) |=> (state_r == ST_SCAN && step_r == '0))
    else $error("test word did not start a scan");

  a_append_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_append && !full) |=> (vtx_total_r == $past(vtx_total_r) + TW'(1)))
    else $error("append word not counted");

  a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |=> !out_valid)
    else $error("result word without a test");

endmodule
